>>> design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// implication after a fixed number of cycles
`define ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed: delayed implication");

`endif

>>> design/isr_pkg.sv
// shared constants, types and the recurrence step for the square root block
package isr_pkg;

  localparam int RADICAND_WIDTH = 32;
  localparam int STEPS          = (RADICAND_WIDTH + 1) / 2;
  localparam int PAD_WIDTH      = 2 * STEPS;
  localparam int REM_WIDTH      = STEPS + 2;
  localparam int ROOT_WIDTH     = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);
  // accept edge to result cycle: front register, queue slot, one stage per step
  localparam int LATENCY        = STEPS + 2;

  // one queued transaction
  typedef struct packed {
    logic [PAD_WIDTH-1:0] radicand;
    logic                 zero;
  } item_t;

  // queue status seen by the front part
  typedef struct packed {
    logic can_push;
    logic pop;
  } qstat_t;

  // partial remainder and root between steps
  typedef struct packed {
    logic [REM_WIDTH-1:0] rem;
    logic [STEPS-1:0]     root;
  } step_t;

  // one restoring step: bring down two bits, try 4*root+1
  function automatic step_t isr_step(input step_t cur, input logic [1:0] pair);
    logic [REM_WIDTH-1:0] rem_sh;
    logic [REM_WIDTH-1:0] trial;
    step_t                nxt;
    rem_sh   = {cur.rem[REM_WIDTH-3:0], pair};
    trial    = {cur.root, 2'b01};
    nxt.root = {cur.root[STEPS-2:0], 1'b0};
    nxt.rem  = rem_sh;
    if (rem_sh >= trial) begin
      nxt.rem     = rem_sh - trial;
      nxt.root[0] = 1'b1;
    end
    return nxt;
  endfunction

endpackage

>>> design/isr_front.sv
// front part: accepts a radicand, pads it and flags the zero case
module isr_front
  import isr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [RADICAND_WIDTH-1:0] radicand_i,
  input  qstat_t                    qstat_i,
  output logic                      push_o,
  output item_t                     item_o
);

  logic  front_v_q, front_v_d;
  item_t item_q;
  logic  accept;

  // hand the held transaction to the queue when there is room
  assign push_o = front_v_q && qstat_i.can_push;
  assign busy   = front_v_q && !qstat_i.can_push;
  assign accept = start && !busy;
  assign item_o = item_q;

  // valid flag
  always_comb begin
    front_v_d = front_v_q;
    if (accept) begin
      front_v_d = 1'b1;
    end else if (push_o) begin
      front_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else begin
      front_v_q <= front_v_d;
    end
  end

  // payload capture with classification
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.radicand <= PAD_WIDTH'(radicand_i);
      item_q.zero     <= (radicand_i == '0);
    end
  end

endmodule

>>> design/isr_queue.sv
// short queue between front and back parts
module isr_queue
  import isr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  output qstat_t qstat_o,
  output logic   head_v_o,
  output item_t  head_o
);

  item_t                 slot_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                  pop;

  // the back part takes a transaction every cycle that the queue holds one
  assign pop              = (cnt_q != '0);
  assign head_v_o         = pop;
  assign head_o           = slot_q[rd_ptr_q];
  assign qstat_o.pop      = pop;
  assign qstat_o.can_push = (cnt_q != QCNT_WIDTH'(QUEUE_DEPTH)) || pop;

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> design/isr_back.sv
// back part: one pipeline stage per root bit
module isr_back
  import isr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_v_i,
  input  item_t                 head_i,
  output logic                  result_valid_o,
  output logic [ROOT_WIDTH-1:0] root_o,
  output logic                  last_zero_o
);

  logic                 v_q    [STEPS];
  step_t                st_q   [STEPS];
  logic [PAD_WIDTH-1:0] rad_q  [STEPS];
  logic                 zero_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic                 in_v;
    step_t                in_st;
    logic [PAD_WIDTH-1:0] in_rad;
    logic                 in_zero;

    // stage input: queue head for the first step, previous stage otherwise
    if (s == 0) begin : g_first
      assign in_v    = head_v_i;
      assign in_st   = '0;
      assign in_rad  = head_i.radicand;
      assign in_zero = head_i.zero;
    end else begin : g_next
      assign in_v    = v_q[s-1];
      assign in_st   = st_q[s-1];
      assign in_rad  = rad_q[s-1];
      assign in_zero = zero_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= in_v;
      end
    end

    // step datapath, top two bits brought down each stage
    always_ff @(posedge clk_i) begin
      st_q[s]   <= isr_step(in_st, in_rad[PAD_WIDTH-1 -: 2]);
      rad_q[s]  <= {in_rad[PAD_WIDTH-3:0], 2'b00};
      zero_q[s] <= in_zero;
    end
  end

  // result strobe and root
  assign result_valid_o = v_q[STEPS-1];
  assign last_zero_o    = zero_q[STEPS-1];
  assign root_o         = zero_q[STEPS-1] ? '0 : ROOT_WIDTH'(st_q[STEPS-1].root);

endmodule

>>> design/integer_square_root_32.sv
// floor square root of a 32-bit radicand, restoring digit-by-digit method
// registered path from accept to result strobe: front register, one queue slot,
// then 16 pipeline stages, one per root bit
// throughput: one transaction per cycle; the 16-stage recurrence pipeline sets it
// reset: asynchronous active low, clears all valid flags and queue pointers
// results cannot be stalled, so busy stays low in normal use
module integer_square_root_32
  import isr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [RADICAND_WIDTH-1:0] radicand_i,
  output logic                      result_valid_o,
  output logic [ROOT_WIDTH-1:0]     root_o
);

`include "assert_macros.svh"

  qstat_t qstat;
  logic   push;
  item_t  item;
  logic   head_v;
  item_t  head;
  logic   last_zero;

  // accept and classify
  isr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .radicand_i (radicand_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .item_o     (item)
  );

  // decoupling queue
  isr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item),
    .qstat_o  (qstat),
    .head_v_o (head_v),
    .head_o   (head)
  );

  // recurrence pipeline
  isr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_v_i       (head_v),
    .head_i         (head),
    .result_valid_o (result_valid_o),
    .root_o         (root_o),
    .last_zero_o    (last_zero)
  );

  // checks on the pipeline and queue
  `ASSERT_DLY(a_fixed_latency, clk_i, rst_ni, start && !busy, LATENCY, result_valid_o)
  `ASSERT_IMP(a_busy_only_when_stuck, clk_i, rst_ni, busy, !qstat.can_push)
  `ASSERT_IMP(a_zero_gives_zero, clk_i, rst_ni, result_valid_o && last_zero, root_o == '0)
  `ASSERT_IMP(a_queue_drains, clk_i, rst_ni, push && !qstat.pop, qstat.can_push)

endmodule

>>> test/integer_square_root_32_checker.sv
// checker for the square root block: predicts each root and compares it with the result strobe
module integer_square_root_32_checker
  import isr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [RADICAND_WIDTH-1:0] radicand_i,
  input  logic                      result_valid_i,
  input  logic [ROOT_WIDTH-1:0]     root_i,
  output int                        mismatches_o,
  output int                        roots_pending_o,
  output int                        radicands_taken_o,
  output int                        roots_checked_o
);

  // one outstanding transaction: the radicand and the root it must give
  typedef struct {
    logic [RADICAND_WIDTH-1:0] radicand;
    logic [ROOT_WIDTH-1:0]     root;
  } root_due_t;

  localparam int PRINT_CAP = 30;

  root_due_t roots_due[$];
  int        mismatches    = 0;
  int        taken         = 0;
  int        checked       = 0;

  // floor square root, two radicand bits per step from the top
  function automatic logic [ROOT_WIDTH-1:0] floor_root(input logic [RADICAND_WIDTH-1:0] value);
    logic [19:0]           partial;
    logic [19:0]           trial;
    logic [ROOT_WIDTH-1:0] digits;
    partial = '0;
    digits  = '0;
    for (int pair = 15; pair >= 0; pair--) begin
      partial = {partial[17:0], value[2*pair+1 -: 2]};
      trial   = {2'b00, digits, 2'b01};
      digits  = {digits[ROOT_WIDTH-2:0], 1'b0};
      if (partial >= trial) begin
        partial   = partial - trial;
        digits[0] = 1'b1;
      end
    end
    return digits;
  endfunction

  // one line per failure, printing stops after a while but counting goes on
  task automatic report_mismatch(input string what, input logic [RADICAND_WIDTH-1:0] radicand,
                                 input logic [ROOT_WIDTH-1:0] want,
                                 input logic [ROOT_WIDTH-1:0] got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch: %s radicand=%h expected root=%h got=%h", what, radicand, want, got);
  endtask

  // results first, so a transaction accepted at this edge cannot match
  always @(posedge clk_i) begin
    root_due_t head;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (roots_due.size() == 0) begin
          report_mismatch("unexpected result", '0, '0, root_i);
        end else begin
          head = roots_due.pop_front();
          checked++;
          if (root_i !== head.root)
            report_mismatch("wrong root", head.radicand, head.root, root_i);
        end
      end
      if (start_i && !busy_i) begin
        head.radicand = radicand_i;
        head.root     = floor_root(radicand_i);
        roots_due.push_back(head);
        taken++;
      end
    end
    mismatches_o      <= mismatches;
    roots_pending_o   <= roots_due.size();
    radicands_taken_o <= taken;
    roots_checked_o   <= checked;
  end

endmodule

>>> test/integer_square_root_32_test.sv
// testbench top for the square root block: clock, reset, radicand stimulus and verdict
module integer_square_root_32_test;
  import isr_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_ITEMS   = 130;
  localparam int CYCLE_LIMIT  = 200000;

  // shapes of random radicands
  typedef enum int {
    KIND_ANY,
    KIND_TINY,
    KIND_SQUARE,
    KIND_SQUARE_BELOW,
    KIND_SQUARE_TOP,
    KIND_TOP_PAIR,
    KIND_POWER_OF_TWO
  } radicand_kind_e;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      start        = 1'b0;
  logic                      busy;
  logic [RADICAND_WIDTH-1:0] radicand     = '0;
  logic                      result_valid;
  logic [ROOT_WIDTH-1:0]     root;
  int                        mismatches;
  int                        roots_pending;
  int                        radicands_taken;
  int                        roots_checked;
  int                        cycles       = 0;

  always #4 clk = ~clk;

  integer_square_root_32 DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .radicand_i     (radicand),
    .result_valid_o (result_valid),
    .root_o         (root)
  );

  integer_square_root_32_checker checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_i            (busy),
    .radicand_i        (radicand),
    .result_valid_i    (result_valid),
    .root_i            (root),
    .mismatches_o      (mismatches),
    .roots_pending_o   (roots_pending),
    .radicands_taken_o (radicands_taken),
    .roots_checked_o   (roots_checked)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d roots still due", cycles, roots_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one transaction, after an optional idle gap with junk on the radicand bus
  task automatic send_radicand(input logic [RADICAND_WIDTH-1:0] value, input int gap);
    if (gap > 0) begin
      start    <= 1'b0;
      radicand <= $urandom();
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    radicand <= value;
    do @(posedge clk); while (busy);
  endtask

  // hold the sender until every root has come back
  task automatic drain_roots();
    start <= 1'b0;
    @(posedge clk);
    while (roots_pending != 0) @(posedge clk);
  endtask

  function automatic logic [RADICAND_WIDTH-1:0] pick_radicand();
    radicand_kind_e            kind;
    logic [ROOT_WIDTH-1:0]     base;
    logic [RADICAND_WIDTH-1:0] square;
    kind   = radicand_kind_e'($urandom_range(0, 9) > 6 ? $urandom_range(1, 6) : 0);
    base   = ROOT_WIDTH'($urandom());
    square = {16'b0, base} * {16'b0, base};
    case (kind)
      KIND_TINY:         return $urandom_range(0, 1023);
      KIND_SQUARE:       return square;
      KIND_SQUARE_BELOW: return square - 1;
      KIND_SQUARE_TOP:   return square + {base, 1'b0};
      KIND_TOP_PAIR:     return {2'($urandom_range(0, 3)), 30'($urandom())};
      KIND_POWER_OF_TWO: return 32'h1 << $urandom_range(0, 31);
      default:           return $urandom();
    endcase
  endfunction

  initial begin
    logic [RADICAND_WIDTH-1:0] corner_values[$];
    int                        idle_odds;
    corner_values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                      32'h0000_0004, 32'h0000_0008, 32'h0000_0009, 32'hFFFF_FFFF,
                      32'hFFFE_0001, 32'hFFFE_0000, 32'h4000_0000, 32'h8000_0000,
                      32'hC000_0000, 32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'hBFFF_FFFF,
                      32'h0001_0000, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner radicands back to back, then let the pipeline empty
    foreach (corner_values[i]) send_radicand(corner_values[i], 0);
    drain_roots();

    // random radicands, idle density changes every hundred transactions
    idle_odds = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) idle_odds = $urandom_range(0, 3);
      if (n == RANDOM_ITEMS / 2) drain_roots();
      send_radicand(pick_radicand(),
                    (idle_odds != 0 && $urandom_range(0, 3) < idle_odds) ?
                    $urandom_range(1, 8) : 0);
    end

    // closing stretch at full rate
    for (int n = 0; n < CALM_ITEMS; n++) send_radicand(pick_radicand(), 0);
    start <= 1'b0;

    while (roots_pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d radicands, %0d roots checked: zero, all ones, top digit pairs,",
             radicands_taken, roots_checked);
    $display("exact squares and their neighbors, powers of two, with and without idle gaps");
    if (mismatches == 0 && roots_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
